FILE: design/kps_pkg.sv
package kps_pkg;

  localparam int ROWS = 4;
  localparam int COLS = 4;
  localparam int KEYS = ROWS * COLS;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int KEY_W = $clog2(KEYS + 1);
  localparam int CODE_W = 6;
  localparam int COLBITS_W = 4;
  localparam int DRIVE_W = 4;
  localparam int HOLD_W = 8;
  localparam int DEBOUNCE_SAMPLES_DEF = 8;

  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
  localparam logic [HOLD_W-1:0] LONG_PRESS_RST = 8'd250;

  typedef struct packed {
    logic                 sample_now;
    logic [COLBITS_W-1:0] column_bits;
    logic                 hold_tick;
    logic                 second_tick;
  } kps_item_t;

  typedef struct packed {
    logic               key_valid;
    logic [CODE_W-1:0]  key_code;
    logic               short_beep;
    logic               long_beep;
    logic [DRIVE_W-1:0] row_drive;
  } kps_result_t;

  // Row r pulls drive bit ROWS-1-r low; rows that fall outside the field drive nothing.
  function automatic logic [DRIVE_W-1:0] drive_pattern(input logic [ROW_W-1:0] row);
    logic [DRIVE_W-1:0] pat;
    int                 bit_pos;
    pat = '1;
    bit_pos = ROWS - 1 - int'(row);
    if (bit_pos < DRIVE_W) begin
      pat[bit_pos] = 1'b0;
    end
    return pat;
  endfunction

endpackage

FILE: design/kps_in_reg.sv
module kps_in_reg
  import kps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  kps_item_t in_item,
  input  logic      out_free,
  output logic      commit,
  output kps_item_t item
);

  logic      valid_r;
  logic      valid_nxt;
  kps_item_t item_r;
  logic      accept;

  // The held item leaves whenever the result register can take its result.
  assign commit   = valid_r && out_free;
  assign in_stall = valid_r && !out_free;
  assign accept   = in_valid && !in_stall;
  assign item     = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (commit) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: design/kps_scan_core.sv
module kps_scan_core
  import kps_pkg::*;
#(
  parameter int DEBOUNCE_SAMPLES = DEBOUNCE_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [HOLD_W-1:0] cfg_data,
  input  logic              commit,
  input  kps_item_t         item,
  output kps_result_t       result
);

  localparam logic [DEBOUNCE_SAMPLES-1:0] HIST_ONES = '1;

  logic [HOLD_W-1:0]           lpt_r;
  logic [DEBOUNCE_SAMPLES-1:0] hist_r     [ROWS][COLS];
  logic [DEBOUNCE_SAMPLES-1:0] hist_nxt   [ROWS][COLS];
  logic [COLS-1:0]             marks_r    [ROWS];
  logic [COLS-1:0]             marks_nxt  [ROWS];
  logic [KEY_W-1:0]            pressed_r  [ROWS];
  logic [KEY_W-1:0]            pressed_nxt[ROWS];
  logic [KEY_W-1:0]            held_r     [ROWS];
  logic [KEY_W-1:0]            held_nxt   [ROWS];
  logic [ROWS-1:0]             cnt_flags_r;
  logic [ROWS-1:0]             cnt_flags_nxt;
  logic [HOLD_W-1:0]           hold_r;
  logic [HOLD_W-1:0]           hold_nxt;
  logic [ROW_W-1:0]            row_r;
  logic [ROW_W-1:0]            row_nxt;
  logic                        sec_r;
  logic                        sec_nxt;
  logic [ROWS-1:0]             held_nz;

  always_comb begin
    logic [ROW_W-1:0]            r;
    logic [CODE_W-1:0]           code;
    logic [COL_W-1:0]            col_w;
    logic [DEBOUNCE_SAMPLES-1:0] h;
    logic                        lvl;
    logic                        lbeep;

    hist_nxt      = hist_r;
    marks_nxt     = marks_r;
    pressed_nxt   = pressed_r;
    held_nxt      = held_r;
    cnt_flags_nxt = cnt_flags_r;
    row_nxt       = row_r;
    r             = row_r;
    code          = '0;
    col_w         = '0;
    lbeep         = 1'b0;
    h             = '0;
    lvl           = 1'b1;

    // Tick pulses take effect ahead of the scan of the same item.
    hold_nxt = hold_r;
    if (item.hold_tick && hold_r != HOLD_MAX) begin
      hold_nxt = hold_r + 1'b1;
    end
    sec_nxt = sec_r | item.second_tick;

    if (item.sample_now) begin
      for (int c = 0; c < COLS; c++) begin
        lvl = (c < COLBITS_W) ? item.column_bits[c] : 1'b1;
        h   = {hist_r[r][c][DEBOUNCE_SAMPLES-2:0], lvl};
        hist_nxt[r][c] = h;
        if (!marks_r[r][c] && h == '0) begin
          marks_nxt[r][c] = 1'b1;
          code  = (CODE_W'(r) << COL_W) + CODE_W'(c) + CODE_W'(1);
          col_w = COL_W'(c);
        end else if (h == HIST_ONES) begin
          marks_nxt[r][c] = 1'b0;
        end
      end

      if (held_r[r] != '0) begin
        if (code != CODE_W'(held_r[r])) begin
          held_nxt[r]    = '0;
          pressed_nxt[r] = '0;
        end else begin
          marks_nxt[r][col_w] = 1'b0;
          code = CODE_W'(held_r[r]) + CODE_W'(KEYS);
        end
      end else if (code != '0) begin
        marks_nxt[r][col_w] = 1'b0;
        if (!cnt_flags_r[r]) begin
          pressed_nxt[r]   = KEY_W'(code);
          hold_nxt         = '0;
          cnt_flags_nxt[r] = 1'b1;
        end else if (code == CODE_W'(pressed_r[r])) begin
          code = '0;
        end else begin
          pressed_nxt[r] = KEY_W'(code);
          hold_nxt       = '0;
        end
        if (hold_nxt >= lpt_r) begin
          cnt_flags_nxt[r] = 1'b0;
          held_nxt[r]      = pressed_nxt[r];
          code  = CODE_W'(pressed_nxt[r]) + CODE_W'(KEYS);
          lbeep = 1'b1;
        end
      end else begin
        held_nxt[r]      = '0;
        pressed_nxt[r]   = '0;
        cnt_flags_nxt[r] = 1'b0;
      end

      // A long code needs a pending one-second pulse and uses it up.
      if (code > CODE_W'(KEYS)) begin
        if (sec_nxt) begin
          sec_nxt = 1'b0;
        end else begin
          code = '0;
        end
      end

      row_nxt = (r == ROW_W'(ROWS - 1)) ? '0 : r + 1'b1;
    end

    result.key_valid  = (code != '0);
    result.key_code   = code;
    result.short_beep = (code != '0) && (code <= CODE_W'(KEYS));
    result.long_beep  = lbeep;
    result.row_drive  = drive_pattern(row_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpt_r <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      lpt_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROWS; i++) begin
        for (int j = 0; j < COLS; j++) begin
          hist_r[i][j] <= HIST_ONES;
        end
        marks_r[i]   <= '0;
        pressed_r[i] <= '0;
        held_r[i]    <= '0;
      end
      cnt_flags_r <= '0;
      hold_r      <= '0;
      row_r       <= '0;
      sec_r       <= 1'b0;
    end else if (commit) begin
      hist_r      <= hist_nxt;
      marks_r     <= marks_nxt;
      pressed_r   <= pressed_nxt;
      held_r      <= held_nxt;
      cnt_flags_r <= cnt_flags_nxt;
      hold_r      <= hold_nxt;
      row_r       <= row_nxt;
      sec_r       <= sec_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      held_nz[i] = (held_r[i] != '0);
    end
  end

  // A row is either counting toward a long press or already holding one, never both.
  a_count_xor_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_flags_r & held_nz) == '0)
    else $error("row both counting and holding a long press");

  a_state_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(hold_r) && $stable(row_r) && $stable(sec_r))
    else $error("scan state changed without an item");

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    commit && item.sample_now |=>
      row_r == (($past(row_r) == ROW_W'(ROWS - 1)) ? '0 : $past(row_r) + 1'b1))
    else $error("row index did not advance on a sample tick");

  // The input register holds no item before the first one arrives, so only
  // results that are committed are checked.
  a_long_beep_code: assert property (@(posedge clk) disable iff (!rst_n)
    commit && result.long_beep |-> item.sample_now && !result.short_beep)
    else $error("long beep with a short code or without a scan");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> result.key_code <= CODE_W'(2 * KEYS))
    else $error("key code out of range");

endmodule

FILE: design/kps_out_reg.sv
module kps_out_reg
  import kps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        commit,
  input  kps_result_t result,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_stall,
  output kps_result_t out_result
);

  logic        valid_r;
  logic        valid_nxt;
  kps_result_t result_r;

  assign out_free   = !valid_r || !out_stall;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (commit) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result_r <= result;
    end
  end

endmodule

FILE: design/matrix_keypad_scanner_top.sv
// 4x4 active-low keypad scanner with per-key debounce, repeat suppression and long-press
// reporting. Each input item is one step: on sample_now the column levels of the driven row
// are debounced, the row advances and row_drive shows the pattern for the next row; every
// item gives exactly one result item. An accepted item is registered in the input register,
// is evaluated by a single stage of logic against the scan state and is registered in the
// result register once that register can take it; a new item is taken every cycle, and the
// only hold-up is a stalled result register with the input register full.
// The user must write the long-press threshold through the cfg port only while no item is
// in flight; the block itself does not enforce it. The debounce state is cleared directly
// by reset with no start-up sequence.
module matrix_keypad_scanner_top
  import kps_pkg::*;
#(
  parameter int DEBOUNCE_SAMPLES = DEBOUNCE_SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_sample_now,
  input  logic [COLBITS_W-1:0] in_column_bits,
  input  logic                 in_hold_tick,
  input  logic                 in_second_tick,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_key_valid,
  output logic [CODE_W-1:0]    out_key_code,
  output logic                 out_short_beep,
  output logic                 out_long_beep,
  output logic [DRIVE_W-1:0]   out_row_drive,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [HOLD_W-1:0]    cfg_long_press_ticks
);

  kps_item_t   in_item;
  kps_item_t   item;
  kps_result_t result;
  kps_result_t out_result;
  logic        commit;
  logic        out_free;

  assign in_item.sample_now  = in_sample_now;
  assign in_item.column_bits = in_column_bits;
  assign in_item.hold_tick   = in_hold_tick;
  assign in_item.second_tick = in_second_tick;

  assign cfg_ready = 1'b1;

  kps_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_free (out_free),
    .commit   (commit),
    .item     (item)
  );

  kps_scan_core #(
    .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES)
  ) u_scan_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_long_press_ticks),
    .commit   (commit),
    .item     (item),
    .result   (result)
  );

  kps_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (commit),
    .result     (result),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_key_valid  = out_result.key_valid;
  assign out_key_code   = out_result.key_code;
  assign out_short_beep = out_result.short_beep;
  assign out_long_beep  = out_result.long_beep;
  assign out_row_drive  = out_result.row_drive;

endmodule

FILE: dv/matrix_keypad_scanner_top_tb.sv
module matrix_keypad_scanner_top_tb;
  import kps_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HIST_W = DEBOUNCE_SAMPLES_DEF;
  localparam int DIR_ROWS = 20;
  localparam int PHASES = 6;

  typedef struct packed {
    kps_item_t   item;
    logic        typed;
    kps_result_t res;
  } dir_row_t;

  typedef struct {
    bit          typed;
    kps_result_t res;
  } typed_slot_t;

  // Directed items: quiet steps, a full row sweep and every column pattern but 4'hB and 4'hD.
  // Only the first few carry a hand-written expectation.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{1'b0, 4'h0, 1'b0, 1'b0}, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 4'h7}},
    '{'{1'b0, 4'hF, 1'b1, 1'b1}, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 4'h7}},
    '{'{1'b1, 4'hF, 1'b0, 1'b0}, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 4'hB}},
    '{'{1'b1, 4'h0, 1'b0, 1'b0}, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 4'hD}},
    '{'{1'b1, 4'h0, 1'b0, 1'b0}, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 4'hE}},
    '{'{1'b1, 4'h0, 1'b1, 1'b0}, 1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 4'h7}},
    '{'{1'b1, 4'h1, 1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 4'h2, 1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 4'h4, 1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 4'h8, 1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 4'h3, 1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 4'hC, 1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 4'h5, 1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 4'hA, 1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 4'h6, 1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 4'h9, 1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b1, 4'hE, 1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 4'h7, 1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b0, 4'h0, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 4'hF, 1'b0, 1'b0}, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_sample_now = 1'b0;
  logic [COLBITS_W-1:0] in_column_bits = '0;
  logic                 in_hold_tick = 1'b0;
  logic                 in_second_tick = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_key_valid;
  logic [CODE_W-1:0]    out_key_code;
  logic                 out_short_beep;
  logic                 out_long_beep;
  logic [DRIVE_W-1:0]   out_row_drive;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [HOLD_W-1:0]    cfg_long_press_ticks = '0;

  matrix_keypad_scanner_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_sample_now        (in_sample_now),
    .in_column_bits       (in_column_bits),
    .in_hold_tick         (in_hold_tick),
    .in_second_tick       (in_second_tick),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_key_valid        (out_key_valid),
    .out_key_code         (out_key_code),
    .out_short_beep       (out_short_beep),
    .out_long_beep        (out_long_beep),
    .out_row_drive        (out_row_drive),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_long_press_ticks (cfg_long_press_ticks)
  );

  always #4 clk = ~clk;

  // Scanner state as the checker sees it.
  logic [HIST_W-1:0] key_hist [ROWS][COLS];
  logic [COLS-1:0]   down_marks [ROWS];
  int                row_pressed [ROWS];
  int                row_held [ROWS];
  logic [ROWS-1:0]   row_counting;
  logic [HOLD_W-1:0] hold_cnt;
  int                scan_row;
  bit                sec_latched;
  logic [HOLD_W-1:0] long_ticks;

  kps_result_t expected_results [$];
  typed_slot_t table_results [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          gen_row = 0;
  logic        hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;
  int          hold_off_left = 0;

  function automatic void clear_scanner();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        key_hist[r][c] = '1;
      end
      down_marks[r] = '0;
      row_pressed[r] = 0;
      row_held[r] = 0;
    end
    row_counting = '0;
    hold_cnt = '0;
    scan_row = 0;
    sec_latched = 1'b0;
    long_ticks = LONG_PRESS_RST;
  endfunction

  function automatic kps_result_t scan_step(input kps_item_t it);
    int                code;
    bit                lbeep;
    int                r;
    logic [HIST_W-1:0] h;
    kps_result_t       res;
    code = 0;
    lbeep = 1'b0;
    r = scan_row;
    if (it.hold_tick && hold_cnt != HOLD_MAX) begin
      hold_cnt = hold_cnt + 1'b1;
    end
    if (it.second_tick) begin
      sec_latched = 1'b1;
    end
    if (it.sample_now) begin
      for (int c = 0; c < COLS; c++) begin
        h = {key_hist[r][c][HIST_W-2:0], it.column_bits[c]};
        key_hist[r][c] = h;
        // The highest qualifying column overwrites lower ones.
        if (!down_marks[r][c] && h == '0) begin
          down_marks[r][c] = 1'b1;
          code = COLS * r + c + 1;
        end else if (h == '1) begin
          down_marks[r][c] = 1'b0;
        end
      end
      if (row_held[r] != 0) begin
        if (code != row_held[r]) begin
          row_held[r] = 0;
          row_pressed[r] = 0;
        end else begin
          down_marks[r][(code - 1) % COLS] = 1'b0;
          code = row_held[r] + KEYS;
        end
      end else if (code != 0) begin
        if (!row_counting[r]) begin
          row_pressed[r] = code;
          hold_cnt = '0;
          row_counting[r] = 1'b1;
          down_marks[r][(code - 1) % COLS] = 1'b0;
        end else if (code == row_pressed[r]) begin
          down_marks[r][(code - 1) % COLS] = 1'b0;
          code = 0;
        end else begin
          row_pressed[r] = code;
          hold_cnt = '0;
          down_marks[r][(code - 1) % COLS] = 1'b0;
        end
        // A repeat that was just suppressed can still turn into a long press.
        if (hold_cnt >= long_ticks) begin
          row_counting[r] = 1'b0;
          row_held[r] = row_pressed[r];
          code = row_held[r] + KEYS;
          lbeep = 1'b1;
        end
      end else begin
        row_held[r] = 0;
        row_pressed[r] = 0;
        row_counting[r] = 1'b0;
      end
      // Long codes need a latched second pulse; the long beep does not.
      if (code > KEYS) begin
        if (sec_latched) begin
          sec_latched = 1'b0;
        end else begin
          code = 0;
        end
      end
      scan_row = (r + 1) % ROWS;
    end
    res.key_valid = (code != 0);
    res.key_code = code[CODE_W-1:0];
    res.short_beep = (code != 0 && code <= KEYS);
    res.long_beep = lbeep;
    res.row_drive = '1;
    res.row_drive[ROWS-1-scan_row] = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin : checker_blk
    kps_item_t   it;
    kps_result_t pred;
    kps_result_t got;
    kps_result_t want;
    typed_slot_t slot;
    if (!rst_n) begin
      clear_scanner();
    end else begin
      if (cfg_valid && cfg_ready) begin
        long_ticks = cfg_long_press_ticks;
      end
      if (in_valid && !in_stall) begin
        it = '{in_sample_now, in_column_bits, in_hold_tick, in_second_tick};
        pred = scan_step(it);
        slot = table_results.pop_front();
        expected_results.push_back(slot.typed ? slot.res : pred);
      end
      if (out_valid && !out_stall) begin
        got = '{out_key_valid, out_key_code, out_short_beep, out_long_beep, out_row_drive};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: valid=%0d code=%0d short=%0d long=%0d drive=%h",
                     got.key_valid, got.key_code, got.short_beep, got.long_beep,
                     got.row_drive);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.key_valid !== want.key_valid || got.key_code !== want.key_code ||
              got.short_beep !== want.short_beep || got.long_beep !== want.long_beep ||
              got.row_drive !== want.row_drive) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected valid=%0d code=%0d short=%0d long=%0d drive=%h",
                       want.key_valid, want.key_code, want.short_beep, want.long_beep,
                       want.row_drive);
              $display("          got      valid=%0d code=%0d short=%0d long=%0d drive=%h",
                       got.key_valid, got.key_code, got.short_beep, got.long_beep,
                       got.row_drive);
            end
          end
        end
      end
    end
  end

  // Result side: random stalls plus one long hold-off that backs up the pipeline.
  always @(posedge clk) begin
    if (hold_off_left != 0) begin
      out_stall <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_req && !hold_off_done) begin
      out_stall <= 1'b1;
      hold_off_left <= 80;
      hold_off_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(input kps_item_t it, input bit typed, input kps_result_t res);
    typed_slot_t slot;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    slot.typed = typed;
    slot.res = res;
    table_results.push_back(slot);
    in_valid <= 1'b1;
    in_sample_now <= it.sample_now;
    in_column_bits <= it.column_bits;
    in_hold_tick <= it.hold_tick;
    in_second_tick <= it.second_tick;
    do @(posedge clk); while (in_stall);
    if (it.sample_now) begin
      gen_row = (gen_row + 1) % ROWS;
    end
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [HOLD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_long_press_ticks <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One keypad situation held for a number of full scans. Most items carry the
  // held pattern of the driven row; a few are bounces or non-sampling noise.
  task automatic run_episode(input int nscan, input bit long_hold, input int hold_pct,
                             output int sent);
    logic [COLBITS_W-1:0] pad [ROWS];
    int                   samples;
    kps_item_t            it;
    int                   pick;
    samples = 0;
    sent = 0;
    for (int r = 0; r < ROWS; r++) begin
      pick = $urandom_range(99);
      pad[r] = '1;
      if (!long_hold) begin
        if (pick < 35) begin
          pad[r][$urandom_range(COLS - 1)] = 1'b0;
        end else if (pick < 50) begin
          pad[r] = COLBITS_W'($urandom_range(15));
        end
      end
    end
    if (long_hold) begin
      pad[$urandom_range(ROWS - 1)][$urandom_range(COLS - 1)] = 1'b0;
    end
    while (samples < nscan * ROWS) begin
      it.sample_now = long_hold || ($urandom_range(99) < 85);
      it.column_bits = pad[gen_row];
      if (!it.sample_now || (!long_hold && $urandom_range(99) < 5)) begin
        it.column_bits = COLBITS_W'($urandom_range(15));
      end
      it.hold_tick = ($urandom_range(99) < hold_pct);
      it.second_tick = ($urandom_range(99) < 15);
      send_item(it, 1'b0, '0);
      if (it.sample_now) begin
        samples++;
      end
      sent++;
    end
  endtask

  initial begin
    int                thresholds [PHASES];
    int                budgets [PHASES];
    int                phase_items;
    int                sent;
    bit                hold_off_asked;
    thresholds = '{250, 4, 0, 255, 1, 20};
    budgets = '{40, 80, 50, 310, 40, 40};
    hold_off_asked = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle_pct = 24;
    rcv_idle_pct = 51;
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(DIR_TABLE[i].item, DIR_TABLE[i].typed, DIR_TABLE[i].res);
    end
    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        snd_idle_pct = 24;
        rcv_idle_pct = 51;
      end else if (p < 4) begin
        snd_idle_pct = 51;
        rcv_idle_pct = 24;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      // The first phase runs with the threshold left at its reset value.
      if (p > 0) begin
        in_valid <= 1'b0;
        wait_drained();
        write_threshold(HOLD_W'(thresholds[p]));
      end
      phase_items = 0;
      while (phase_items < budgets[p]) begin
        if (p == 1 && phase_items >= 40 && !hold_off_asked) begin
          hold_off_req <= 1'b1;
          hold_off_asked = 1'b1;
        end
        if (p == 3 && phase_items == 0) begin
          // Keep one key down long enough for the hold counter to saturate.
          run_episode(75, 1'b1, 97, sent);
        end else begin
          run_episode($urandom_range(1, 14), 1'b0, 60, sent);
        end
        phase_items += sent;
      end
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/kps_pkg.sv
design/kps_in_reg.sv
design/kps_scan_core.sv
design/kps_out_reg.sv
design/matrix_keypad_scanner_top.sv
dv/matrix_keypad_scanner_top_tb.sv
